>>> hdl/msd_pkg.sv
`timescale 1ns / 1ps
package msd_pkg;

  localparam int unsigned MAX_NEST = 64;
  localparam int unsigned OC_W     = $clog2(MAX_NEST + 1);
  localparam int unsigned SA_W     = $clog2(MAX_NEST);
  localparam int unsigned STK_W    = 34;

  typedef enum logic [3:0] {
    K_NIL   = 4'd0,
    K_FALSE = 4'd1,
    K_TRUE  = 4'd2,
    K_INT   = 4'd3,
    K_F32   = 4'd4,
    K_F64   = 4'd5,
    K_STR   = 4'd6,
    K_BIN   = 4'd7,
    K_ARRAY = 4'd8,
    K_MAP   = 4'd9,
    K_BYTE  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    E_NONE  = 3'd0,
    E_TRUNC = 3'd1,
    E_DEEP  = 3'd2,
    E_TYPE  = 3'd3,
    E_LEN   = 3'd4,
    E_KEY   = 3'd5,
    E_TRAIL = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    M_HEADER  = 2'd0,
    M_ARGS    = 2'd1,
    M_PAYLOAD = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_CLOSE = 3'd2,
    ST_POPLD = 3'd3,
    ST_FIN   = 3'd4
  } state_e;

  typedef struct packed {
    logic cap;
    logic exec;
    logic close;
    logic popld;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic need_close;
    logic pop_more;
    logic emit_req;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/msd_if.sv
`timescale 1ns / 1ps
interface msd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] doc_length;
  logic        last_byte;
  modport source (output valid, data_byte, doc_length, last_byte, input ready);
  modport sink (input valid, data_byte, doc_length, last_byte, output ready);
endinterface

interface msd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] token_value;
  logic [31:0] item_count;
  logic [6:0]  nest_level;
  logic [2:0]  error_code;
  logic        doc_done;
  modport source (output valid, token_kind, token_value, item_count, nest_level,
                  error_code, doc_done, input ready);
  modport sink (input valid, token_kind, token_value, item_count, nest_level,
                error_code, doc_done, output ready);
endinterface

>>> hdl/msd_ram.sv
`timescale 1ns / 1ps
module msd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/msd_ctrl.sv
`timescale 1ns / 1ps
module msd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msd_pkg::sts_t sts_i,
  output msd_pkg::cmd_t cmd_o
);
  import msd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:  state_d = sts_i.need_close ? ST_CLOSE : ST_FIN;
      ST_CLOSE: state_d = sts_i.pop_more ? ST_POPLD : ST_FIN;
      ST_POPLD: state_d = ST_CLOSE;
      ST_FIN:   if (!sts_i.emit_req || sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      ST_EXEC:  cmd_o.exec  = 1'b1;
      ST_CLOSE: cmd_o.close = 1'b1;
      ST_POPLD: cmd_o.popld = 1'b1;
      ST_FIN:   cmd_o.fin   = !sts_i.emit_req || sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  a_pop_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POPLD |-> $past(state_q) == ST_CLOSE)
    else $error("pop load without close step");
  a_fin_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> state_q == ST_IDLE)
    else $error("finish did not return to idle");
  a_cap_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |=> state_q == ST_EXEC)
    else $error("captured beat not executed");
endmodule

>>> hdl/msd_dp.sv
`timescale 1ns / 1ps
module msd_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msd_pkg::cmd_t cmd_i,
  output msd_pkg::sts_t sts_o,
  input  logic [7:0]    data_byte_i,
  input  logic [31:0]   doc_length_i,
  input  logic          last_byte_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [3:0]    token_kind_o,
  output logic [63:0]   token_value_o,
  output logic [31:0]   item_count_o,
  output logic [6:0]    nest_level_o,
  output logic [2:0]    error_code_o,
  output logic          doc_done_o
);
  import msd_pkg::*;

  function automatic logic [3:0] arg_len(input logic [7:0] b);
    case (b)
      8'hC4, 8'hCC, 8'hD0, 8'hD9: arg_len = 4'd1;
      8'hC5, 8'hCD, 8'hD1, 8'hDA, 8'hDC, 8'hDE: arg_len = 4'd2;
      8'hC6, 8'hCA, 8'hCE, 8'hD2, 8'hDB, 8'hDD, 8'hDF: arg_len = 4'd4;
      8'hCB, 8'hCF, 8'hD3: arg_len = 4'd8;
      default: arg_len = 4'd0;
    endcase
  endfunction

  // uint64 above the signed range, round to nearest even
  function automatic logic [63:0] big_to_f64(input logic [63:0] u);
    logic [53:0] m;
    logic [10:0] e;
    m = {1'b0, u[63:11]};
    e = 11'd1086;
    if (u[10:0] > 11'h400 || (u[10:0] == 11'h400 && u[11])) m = m + 54'd1;
    if (m[53]) begin
      m = m >> 1;
      e = 11'd1087;
    end
    big_to_f64 = {1'b0, e, m[51:0]};
  endfunction

  // captured beat
  logic [7:0]  byte_q;
  logic [31:0] len_q;
  logic        last_q;

  // document state
  mode_e            mode_q, mode_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [3:0]       left_q, left_d;
  logic [63:0]      acc_q, acc_d;
  logic [31:0]      pl_q, pl_d;
  logic [31:0]      pos_q, pos_d;
  logic [OC_W-1:0]  oc_q, oc_d;
  logic [STK_W-1:0] top_q, top_d;
  logic             tdone_q, tdone_d;
  logic             drain_q, drain_d;

  // pending result
  err_e        err_q, err_d;
  logic        have_q, have_d;
  kind_e       tk_q, tk_d;
  logic [63:0] tv_q, tv_d;
  logic [31:0] tc_q, tc_d;
  logic [6:0]  tl_q, tl_d;
  logic        isstr_q, isstr_d;

  // output register
  logic        ov_q;
  logic [3:0]  ok_q;
  logic [63:0] oval_q;
  logic [31:0] ocnt_q;
  logic [6:0]  olvl_q;
  logic [2:0]  oerr_q;
  logic        odone_q;

  logic             ram_we;
  logic [SA_W-1:0]  ram_wa;
  logic [STK_W-1:0] ram_wd;
  logic [STK_W-1:0] ram_rd;
  logic [OC_W-1:0]  oc_m1, oc_m2;

  logic [31:0] pos_inc;
  logic [63:0] acc_new;
  logic        do_sc, do_cont, do_text, is_map;
  kind_e       rk;
  logic [63:0] rv;
  logic [31:0] rn;
  logic [3:0]  al;
  logic [3:0]  left_dec;
  logic [31:0] pl_dec;
  logic [32:0] cl_rem, cl_dec;
  err_e        fin_err;
  logic        emit;
  logic        need_close;
  logic        pop_more;

  assign oc_m1   = oc_q - OC_W'(1);
  assign oc_m2   = oc_q - OC_W'(2);
  assign pos_inc = (&pos_q) ? pos_q : pos_q + 32'd1;
  assign acc_new = {acc_q[55:0], byte_q};
  assign al      = arg_len(byte_q);
  assign left_dec = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
  assign pl_dec  = (pl_q != 32'd0) ? pl_q - 32'd1 : 32'd0;
  assign cl_rem  = top_q[32:0];
  assign cl_dec  = (cl_rem != 33'd0) ? cl_rem - 33'd1 : 33'd0;

  // decode of the item that this beat finishes
  always_comb begin
    do_sc   = 1'b0;
    do_cont = 1'b0;
    do_text = 1'b0;
    is_map  = 1'b0;
    rk      = K_INT;
    rv      = '0;
    rn      = '0;
    if (mode_q == M_ARGS) begin
      case (hdr_q)
        8'hC4, 8'hC5, 8'hC6: begin do_text = 1'b1; rk = K_BIN; rn = acc_new[31:0]; end
        8'hD9, 8'hDA, 8'hDB: begin do_text = 1'b1; rk = K_STR; rn = acc_new[31:0]; end
        8'hDC, 8'hDD: begin do_cont = 1'b1; rk = K_ARRAY; rn = acc_new[31:0]; end
        8'hDE, 8'hDF: begin
          do_cont = 1'b1; is_map = 1'b1; rk = K_MAP; rn = acc_new[31:0];
        end
        8'hCA: begin do_sc = 1'b1; rk = K_F32; rv = {32'd0, acc_new[31:0]}; end
        8'hCB: begin do_sc = 1'b1; rk = K_F64; rv = acc_new; end
        8'hCC, 8'hCD, 8'hCE, 8'hD3: begin do_sc = 1'b1; rv = acc_new; end
        8'hCF: begin
          do_sc = 1'b1;
          if (acc_new[63]) begin rk = K_F64; rv = big_to_f64(acc_new); end
          else rv = acc_new;
        end
        8'hD0: begin do_sc = 1'b1; rv = {{56{acc_new[7]}}, acc_new[7:0]}; end
        8'hD1: begin do_sc = 1'b1; rv = {{48{acc_new[15]}}, acc_new[15:0]}; end
        8'hD2: begin do_sc = 1'b1; rv = {{32{acc_new[31]}}, acc_new[31:0]}; end
        default: do_sc = 1'b0;
      endcase
    end else begin
      if (byte_q <= 8'h7F) begin
        do_sc = 1'b1; rv = {56'd0, byte_q};
      end else if (byte_q >= 8'hE0) begin
        do_sc = 1'b1; rv = {{56{1'b1}}, byte_q};
      end else if (byte_q[7:4] == 4'h8) begin
        do_cont = 1'b1; is_map = 1'b1; rk = K_MAP; rn = {28'd0, byte_q[3:0]};
      end else if (byte_q[7:4] == 4'h9) begin
        do_cont = 1'b1; rk = K_ARRAY; rn = {28'd0, byte_q[3:0]};
      end else if (byte_q[7:5] == 3'b101) begin
        do_text = 1'b1; rk = K_STR; rn = {27'd0, byte_q[4:0]};
      end else if (byte_q == 8'hC0) begin
        do_sc = 1'b1; rk = K_NIL;
      end else if (byte_q == 8'hC2) begin
        do_sc = 1'b1; rk = K_FALSE;
      end else if (byte_q == 8'hC3) begin
        do_sc = 1'b1; rk = K_TRUE;
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    hdr_d   = hdr_q;
    left_d  = left_q;
    acc_d   = acc_q;
    pl_d    = pl_q;
    pos_d   = pos_q;
    oc_d    = oc_q;
    top_d   = top_q;
    tdone_d = tdone_q;
    drain_d = drain_q;
    err_d   = err_q;
    have_d  = have_q;
    tk_d    = tk_q;
    tv_d    = tv_q;
    tc_d    = tc_q;
    tl_d    = tl_q;
    isstr_d = isstr_q;
    ram_we  = 1'b0;
    ram_wa  = oc_q[SA_W-1:0];
    ram_wd  = top_q;
    need_close = 1'b0;
    pop_more   = 1'b0;
    fin_err = err_q;
    if (err_q == E_NONE && !drain_q && last_q && !tdone_q) begin
      fin_err = (mode_q == M_HEADER && oc_q >= OC_W'(MAX_NEST)) ? E_DEEP : E_TRUNC;
    end
    emit = !drain_q && (fin_err != E_NONE || have_q);

    if (cmd_i.exec) begin
      err_d  = E_NONE;
      have_d = 1'b0;
      tl_d   = 7'(oc_q);
      tv_d   = '0;
      tc_d   = '0;
      if (drain_q) begin
        have_d = 1'b0;
      end else if (tdone_q) begin
        err_d = E_TRAIL;
      end else begin
        pos_d = pos_inc;
        if (mode_q == M_PAYLOAD) begin
          have_d = 1'b1;
          tk_d   = K_BYTE;
          tv_d   = {56'd0, byte_q};
          pl_d   = pl_dec;
          if (pl_dec == 32'd0) begin
            mode_d     = M_HEADER;
            need_close = 1'b1;
            isstr_d    = !(hdr_q >= 8'hC4 && hdr_q <= 8'hC6);
          end
        end else if (mode_q == M_HEADER && oc_q >= OC_W'(MAX_NEST)) begin
          err_d = E_DEEP;
        end else if (mode_q == M_ARGS && left_dec != 4'd0) begin
          acc_d  = acc_new;
          left_d = left_dec;
        end else begin
          mode_d = M_HEADER;
          if (mode_q == M_HEADER) hdr_d = byte_q;
          if (do_sc) begin
            have_d = 1'b1; tk_d = rk; tv_d = rv;
            need_close = 1'b1; isstr_d = 1'b0;
          end else if (do_cont) begin
            if (rn > len_q) begin
              err_d = E_LEN;
            end else begin
              have_d = 1'b1; tk_d = rk; tc_d = rn;
              if (rn == 32'd0) begin
                need_close = 1'b1; isstr_d = 1'b0;
              end else if (oc_q >= OC_W'(MAX_NEST)) begin
                err_d = E_DEEP;
              end else begin
                top_d  = is_map ? {1'b1, rn, 1'b0} : {2'b00, rn};
                ram_we = 1'b1;
                ram_wa = oc_q[SA_W-1:0];
                ram_wd = top_d;
                oc_d   = oc_q + OC_W'(1);
              end
            end
          end else if (do_text) begin
            if ({1'b0, pos_inc} + {1'b0, rn} > {1'b0, len_q}) begin
              err_d = E_TRUNC;
            end else begin
              have_d = 1'b1; tk_d = rk; tc_d = rn;
              if (rn == 32'd0) begin
                need_close = 1'b1; isstr_d = (rk == K_STR);
              end else begin
                pl_d = rn; mode_d = M_PAYLOAD;
              end
            end
          end else if (mode_q == M_HEADER && al != 4'd0) begin
            mode_d = M_ARGS; left_d = al; acc_d = '0;
          end else begin
            err_d = E_TYPE;
          end
        end
      end
    end

    // one level of the close walk per step
    if (cmd_i.close) begin
      if (oc_q == '0) begin
        tdone_d = 1'b1;
      end else if (top_q[33] && !cl_rem[0] && !isstr_q) begin
        err_d = E_KEY;
      end else if (cl_dec != 33'd0) begin
        top_d  = {top_q[33], cl_dec};
        ram_we = 1'b1;
        ram_wa = oc_m1[SA_W-1:0];
        ram_wd = top_d;
      end else begin
        oc_d    = oc_m1;
        isstr_d = 1'b0;
        if (oc_q == OC_W'(1)) tdone_d = 1'b1;
        else pop_more = 1'b1;
      end
    end

    if (cmd_i.popld) top_d = ram_rd;

    if (cmd_i.fin) begin
      if (fin_err != E_NONE || last_q) begin
        mode_d  = M_HEADER;
        hdr_d   = '0;
        left_d  = '0;
        acc_d   = '0;
        pl_d    = '0;
        pos_d   = '0;
        oc_d    = '0;
        tdone_d = 1'b0;
        drain_d = fin_err != E_NONE && !last_q && !drain_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      byte_q <= data_byte_i;
      len_q  <= doc_length_i;
      last_q <= last_byte_i;
    end
    top_q   <= top_d;
    have_q  <= have_d;
    tk_q    <= tk_d;
    tv_q    <= tv_d;
    tc_q    <= tc_d;
    tl_q    <= tl_d;
    isstr_q <= isstr_d;
    if (cmd_i.fin && emit) begin
      if (fin_err != E_NONE) begin
        ok_q    <= '0;
        oval_q  <= '0;
        ocnt_q  <= '0;
        olvl_q  <= '0;
        oerr_q  <= fin_err;
        odone_q <= 1'b1;
      end else begin
        ok_q    <= tk_q;
        oval_q  <= tv_q;
        ocnt_q  <= tc_q;
        olvl_q  <= tl_q;
        oerr_q  <= E_NONE;
        odone_q <= last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_HEADER;
      hdr_q   <= '0;
      left_q  <= '0;
      acc_q   <= '0;
      pl_q    <= '0;
      pos_q   <= '0;
      oc_q    <= '0;
      tdone_q <= 1'b0;
      drain_q <= 1'b0;
      err_q   <= E_NONE;
      ov_q    <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      hdr_q   <= hdr_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      pl_q    <= pl_d;
      pos_q   <= pos_d;
      oc_q    <= oc_d;
      tdone_q <= tdone_d;
      drain_q <= drain_d;
      err_q   <= err_d;
      if (cmd_i.fin && emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  msd_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_NEST)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (oc_m2[SA_W-1:0]),
    .rdata_o (ram_rd)
  );

  assign sts_o.need_close = need_close;
  assign sts_o.pop_more   = pop_more;
  assign sts_o.emit_req   = emit;
  assign sts_o.out_free   = !ov_q || out_ready_i;

  assign out_valid_o   = ov_q;
  assign token_kind_o  = ok_q;
  assign token_value_o = oval_q;
  assign item_count_o  = ocnt_q;
  assign nest_level_o  = olvl_q;
  assign error_code_o  = oerr_q;
  assign doc_done_o    = odone_q;

  a_oc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oc_q <= OC_W'(MAX_NEST))
    else $error("nesting counter beyond limit");
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_PAYLOAD |-> pl_q != 32'd0)
    else $error("payload mode with nothing left");
  a_drain_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> !tdone_q && oc_q == '0)
    else $error("drain with live document state");
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oerr_q != E_NONE |-> odone_q)
    else $error("error beat without document end");
endmodule

>>> hdl/msgpack_stream_decoder_top.sv
`timescale 1ns / 1ps
// streaming messagepack decoder
// in_i carries one document byte per beat with the document length and a
// last-byte flag; out_o carries tokens: scalars, str/bin/array/map headers,
// one beat per str/bin payload byte, and error beats with doc_done set.
// a byte gives zero or one output beat; errors replace the token and the
// rest of the document is then dropped up to its last byte.
// steps: a byte is captured in the idle state and decoded in the exec step;
// a byte that completes an item then walks up the nesting stack in close
// steps, with a pop load between them for each container that it closes
// (the stack is read from a ram with registered read), and the finish step
// loads its token into the output register. a new byte is accepted only
// once the last one has left the finish step.
// the output register lets the next byte be accepted while a token waits.
// when out_o is stalled, a byte that has a token waits in the finish step
// and in_i.ready stays low until the register frees up.
// reset (rst_ni low, asynchronous) empties the output register and returns
// the parser to the start of a document; the stack ram needs no clearing.
module msgpack_stream_decoder_top (
  input logic       clk_i,
  input logic       rst_ni,
  msd_in_if.sink    in_i,
  msd_out_if.source out_o
);
  import msd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (in_i.data_byte),
    .doc_length_i  (in_i.doc_length),
    .last_byte_i   (in_i.last_byte),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .token_kind_o  (out_o.token_kind),
    .token_value_o (out_o.token_value),
    .item_count_o  (out_o.item_count),
    .nest_level_o  (out_o.nest_level),
    .error_code_o  (out_o.error_code),
    .doc_done_o    (out_o.doc_done)
  );
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import msd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RAND_BYTES  = 1300;

  typedef bit [7:0] byte_q_t[$];

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [31:0] count;
    logic [6:0]  level;
    logic [2:0]  err;
    logic        done;
  } token_t;

  logic clk_i;
  logic rst_ni;

  msd_in_if  in_bus ();
  msd_out_if out_bus ();

  msgpack_stream_decoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // decoder state mirror
  mode_e       dec_mode;
  bit [7:0]    dec_hdr;
  int unsigned dec_arg_left;
  bit [63:0]   dec_acc;
  bit [31:0]   dec_pay_left;
  bit [31:0]   dec_pos;
  int unsigned dec_depth;
  bit [33:0]   dec_stack [MAX_NEST];
  bit          dec_top_done;
  bit          dec_drain;
  token_t      dec_tok;
  bit          dec_have_tok;

  token_t      token_q[$];
  int unsigned n_errors;
  int unsigned bytes_sent;
  int unsigned cycles;
  bit          calm;

  function automatic void doc_clear();
    dec_mode     = M_HEADER;
    dec_hdr      = '0;
    dec_arg_left = 0;
    dec_acc      = '0;
    dec_pay_left = '0;
    dec_pos      = '0;
    dec_depth    = 0;
    dec_top_done = 1'b0;
    dec_drain    = 1'b0;
  endfunction

  function automatic void set_tok(kind_e k, bit [63:0] v, bit [63:0] n);
    dec_tok      = '{kind: k, value: v, count: n[31:0], level: dec_depth[6:0],
                     err: E_NONE, done: 1'b0};
    dec_have_tok = 1'b1;
  endfunction

  // count a finished item in its container, popping every container it completes
  function automatic err_e close_item(kind_e k);
    bit [32:0] rem;
    bit        is_map;
    forever begin
      if (dec_depth == 0) begin
        dec_top_done = 1'b1;
        return E_NONE;
      end
      if (dec_depth > MAX_NEST) return E_DEEP;
      rem    = dec_stack[dec_depth-1][32:0];
      is_map = dec_stack[dec_depth-1][33];
      if (is_map && !rem[0] && k != K_STR) return E_KEY;
      if (rem > 0) rem--;
      if (rem > 0) begin
        dec_stack[dec_depth-1] = {is_map, rem};
        return E_NONE;
      end
      k = is_map ? K_MAP : K_ARRAY;
      dec_depth--;
    end
  endfunction

  function automatic err_e open_container(bit is_map, bit [63:0] n, bit [31:0] dl);
    bit [63:0] cnt;
    if (n > {32'd0, dl}) return E_LEN;
    set_tok(is_map ? K_MAP : K_ARRAY, '0, n);
    if (n == 0) return close_item(is_map ? K_MAP : K_ARRAY);
    if (dec_depth >= MAX_NEST) return E_DEEP;
    cnt = is_map ? 2 * n : n;
    dec_stack[dec_depth] = {is_map, cnt[32:0]};
    dec_depth++;
    return E_NONE;
  endfunction

  function automatic err_e open_text(kind_e k, bit [63:0] n, bit [31:0] dl);
    if ({32'd0, dec_pos} + n > {32'd0, dl}) return E_TRUNC;
    set_tok(k, '0, n);
    if (n == 0) return close_item(k);
    dec_pay_left = n[31:0];
    dec_mode     = M_PAYLOAD;
    return E_NONE;
  endfunction

  function automatic err_e scalar_tok(kind_e k, bit [63:0] v);
    set_tok(k, v, '0);
    return close_item(k);
  endfunction

  // uint64 above the signed range as float64, round to nearest even
  function automatic bit [63:0] u64_as_double(bit [63:0] u);
    bit [63:0] m;
    bit [10:0] e;
    m = u >> 11;
    e = 11'd1086;
    if (u[10:0] > 11'h400 || (u[10:0] == 11'h400 && m[0])) m++;
    if (m[53]) begin
      m = m >> 1;
      e++;
    end
    return {1'b0, e, m[51:0]};
  endfunction

  function automatic int unsigned arg_bytes(bit [7:0] b);
    case (b)
      8'hC4, 8'hCC, 8'hD0, 8'hD9:                             return 1;
      8'hC5, 8'hCD, 8'hD1, 8'hDA, 8'hDC, 8'hDE:               return 2;
      8'hC6, 8'hCA, 8'hCE, 8'hD2, 8'hDB, 8'hDD, 8'hDF:        return 4;
      8'hCB, 8'hCF, 8'hD3:                                    return 8;
      default:                                                return 0;
    endcase
  endfunction

  function automatic err_e finish_args(bit [7:0] h, bit [63:0] a, bit [31:0] dl);
    case (h)
      8'hC4, 8'hC5, 8'hC6:       return open_text(K_BIN, a, dl);
      8'hD9, 8'hDA, 8'hDB:       return open_text(K_STR, a, dl);
      8'hDC, 8'hDD:              return open_container(1'b0, a, dl);
      8'hDE, 8'hDF:              return open_container(1'b1, a, dl);
      8'hCA:                     return scalar_tok(K_F32, {32'd0, a[31:0]});
      8'hCB:                     return scalar_tok(K_F64, a);
      8'hCC, 8'hCD, 8'hCE, 8'hD3: return scalar_tok(K_INT, a);
      8'hCF: return a[63] ? scalar_tok(K_F64, u64_as_double(a)) : scalar_tok(K_INT, a);
      8'hD0: return scalar_tok(K_INT, {{56{a[7]}}, a[7:0]});
      8'hD1: return scalar_tok(K_INT, {{48{a[15]}}, a[15:0]});
      8'hD2: return scalar_tok(K_INT, {{32{a[31]}}, a[31:0]});
      default:                   return E_TYPE;
    endcase
  endfunction

  function automatic err_e type_byte(bit [7:0] b, bit [31:0] dl);
    int unsigned n;
    dec_hdr = b;
    if (b <= 8'h7F) return scalar_tok(K_INT, {56'd0, b});
    if (b >= 8'hE0) return scalar_tok(K_INT, {56'hFF_FFFF_FFFF_FFFF, b});
    if (b[7:4] == 4'h8) return open_container(1'b1, {60'd0, b[3:0]}, dl);
    if (b[7:4] == 4'h9) return open_container(1'b0, {60'd0, b[3:0]}, dl);
    if (b[7:5] == 3'b101) return open_text(K_STR, {59'd0, b[4:0]}, dl);
    if (b == 8'hC0) return scalar_tok(K_NIL, '0);
    if (b == 8'hC2) return scalar_tok(K_FALSE, '0);
    if (b == 8'hC3) return scalar_tok(K_TRUE, '0);
    n = arg_bytes(b);
    if (n == 0) return E_TYPE;
    dec_arg_left = n;
    dec_acc      = '0;
    dec_mode     = M_ARGS;
    return E_NONE;
  endfunction

  function automatic bit decode_byte(bit [7:0] b, bit [31:0] dl, bit last,
                                     output token_t r);
    err_e e;
    e = E_NONE;
    r = '0;
    dec_have_tok = 1'b0;
    if (dec_drain) begin
      if (last) doc_clear();
      return 1'b0;
    end
    if (dec_top_done) begin
      e = E_TRAIL;
    end else begin
      if (dec_pos != 32'hFFFF_FFFF) dec_pos++;
      case (dec_mode)
        M_ARGS: begin
          dec_acc = {dec_acc[55:0], b};
          if (dec_arg_left > 0) dec_arg_left--;
          if (dec_arg_left == 0) begin
            dec_mode = M_HEADER;
            e = finish_args(dec_hdr, dec_acc, dl);
          end
        end
        M_PAYLOAD: begin
          set_tok(K_BYTE, {56'd0, b}, '0);
          if (dec_pay_left > 0) dec_pay_left--;
          if (dec_pay_left == 0) begin
            dec_mode = M_HEADER;
            e = close_item((dec_hdr >= 8'hC4 && dec_hdr <= 8'hC6) ? K_BIN : K_STR);
          end
        end
        default: begin
          dec_mode = M_HEADER;
          if (dec_depth >= MAX_NEST) e = E_DEEP;
          else e = type_byte(b, dl);
        end
      endcase
      if (e == E_NONE && last && !dec_top_done)
        e = (dec_mode == M_HEADER && dec_depth >= MAX_NEST) ? E_DEEP : E_TRUNC;
    end
    if (e != E_NONE) begin
      r.err  = e;
      r.done = 1'b1;
      doc_clear();
      if (!last) dec_drain = 1'b1;
      return 1'b1;
    end
    if (!dec_have_tok) begin
      if (last) doc_clear();
      return 1'b0;
    end
    r      = dec_tok;
    r.done = last;
    if (last) doc_clear();
    return 1'b1;
  endfunction

  // byte source
  task automatic send_byte(bit [7:0] b, bit [31:0] dl, bit last);
    int unsigned gap;
    token_t      t;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.doc_length <= dl;
    in_bus.last_byte  <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    bytes_sent++;
    if (decode_byte(b, dl, last, t)) token_q.insert(token_q.size(), t);
  endtask

  task automatic send_doc(byte_q_t d, bit [31:0] dl);
    foreach (d[i]) send_byte(d[i], dl, i == d.size() - 1);
  endtask

  task automatic send_exact(byte_q_t d);
    send_doc(d, d.size());
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (token_q.size() != 0);
  endtask

  function automatic void add_byte(ref byte_q_t q, input bit [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void put_be(ref byte_q_t q, input bit [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) add_byte(q, v[8*i +: 8]);
  endfunction

  function automatic void gen_text(ref byte_q_t q, input bit is_bin);
    int unsigned n;
    int unsigned form;
    n    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
    form = $urandom_range(0, 3);
    if (is_bin) begin
      add_byte(q, 8'(8'hC4 + (form % 3)));
      put_be(q, 64'(n), 1 << (form % 3));
    end else if (form == 0 && n < 32) begin
      add_byte(q, 8'hA0 | n[7:0]);
    end else begin
      add_byte(q, 8'(8'hD9 + (form % 3)));
      put_be(q, 64'(n), 1 << (form % 3));
    end
    repeat (n) add_byte(q, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_item(ref byte_q_t q, input int unsigned lvl);
    int unsigned sel;
    int unsigned n;
    bit [63:0]   v;
    sel = $urandom_range(0, (lvl < 4) ? 13 : 9);
    v   = {$urandom, $urandom};
    case (sel)
      0: add_byte(q, 8'($urandom_range(0, 8'h7F)));
      1: add_byte(q, 8'($urandom_range(8'hE0, 8'hFF)));
      2: add_byte(q, 8'(8'hC0 + 2 * $urandom_range(0, 1) +
                        $urandom_range(0, 1) * ($urandom & 1)));
      3: begin
        n = $urandom_range(0, 3);
        add_byte(q, 8'(8'hCC + n));
        if (n == 3 && $urandom_range(0, 1)) v[63] = 1'b1;
        put_be(q, v, 1 << n);
      end
      4: begin
        n = $urandom_range(0, 3);
        add_byte(q, 8'(8'hD0 + n));
        put_be(q, v, 1 << n);
      end
      5: begin
        n = $urandom_range(0, 1);
        add_byte(q, 8'(8'hCA + n));
        put_be(q, v, n ? 8 : 4);
      end
      6, 7: gen_text(q, 1'b0);
      8, 9: gen_text(q, 1'b1);
      10, 11: begin
        n = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: add_byte(q, 8'h90 | n[7:0]);
          1: begin add_byte(q, 8'hDC); put_be(q, 64'(n), 2); end
          default: begin add_byte(q, 8'hDD); put_be(q, 64'(n), 4); end
        endcase
        repeat (n) gen_item(q, lvl + 1);
      end
      default: begin
        n = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: add_byte(q, 8'h80 | n[7:0]);
          1: begin add_byte(q, 8'hDE); put_be(q, 64'(n), 2); end
          default: begin add_byte(q, 8'hDF); put_be(q, 64'(n), 4); end
        endcase
        repeat (n) begin
          gen_text(q, 1'b0);
          gen_item(q, lvl + 1);
        end
      end
    endcase
  endfunction

  task automatic test_scalars();
    send_exact('{8'h00});
    send_exact('{8'h7F});
    send_exact('{8'hE0});
    send_exact('{8'hC3});
    send_exact('{8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_exact('{8'hD3, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_doc('{8'hA2, 8'h41, 8'hFF}, 32'hFFFF_FFFF);
  endtask

  task automatic test_nesting();
    byte_q_t d;
    // full depth, then one more item inside the deepest level
    repeat (MAX_NEST) add_byte(d, 8'h91);
    add_byte(d, 8'hC2);
    send_exact(d);
    // one level too many
    d.delete();
    repeat (MAX_NEST + 1) add_byte(d, 8'h91);
    send_exact(d);
    // document ends with every level open
    d.delete();
    repeat (MAX_NEST) add_byte(d, 8'h91);
    send_exact(d);
  endtask

  task automatic test_errors();
    send_exact('{8'hC1, 8'h00});
    send_exact('{8'hD4, 8'h00, 8'h00});
    send_exact('{8'h81, 8'h01, 8'h02});
    send_exact('{8'hC0, 8'hC0});
    send_exact('{8'hDC, 8'h00, 8'h09});
    send_exact('{8'hA5, 8'h41});
    send_exact('{8'hDE, 8'h00});
    send_doc('{8'h01}, 32'd1);
  endtask

  task automatic test_random();
    byte_q_t     d;
    int unsigned docs;
    bit [31:0]   dl;
    docs = 0;
    while (bytes_sent < RAND_BYTES) begin
      d.delete();
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      case ($urandom_range(0, 19))
        0, 1: repeat ($urandom_range(1, 8)) add_byte(d, 8'($urandom_range(0, 255)));
        2: begin gen_item(d, 0); void'(d.pop_back()); end
        3: begin gen_item(d, 0); add_byte(d, 8'($urandom_range(0, 255))); end
        4: begin add_byte(d, 8'h81); gen_item(d, 1); gen_item(d, 1); end
        5: begin add_byte(d, 8'h92); add_byte(d, 8'($urandom_range(8'hC1, 8'hD8))); end
        default: gen_item(d, 0);
      endcase
      case ($urandom_range(0, 9))
        0: dl = $urandom;
        1: dl = d.size() + $urandom_range(1, 100);
        2: dl = $urandom_range(1, d.size());
        default: dl = d.size();
      endcase
      if (dl == 0) dl = 1;
      send_doc(d, dl);
      docs++;
      if (docs == 40) wait_drained();
    end
    calm = 1'b0;
  endtask

  // token sink with random stalls
  initial begin
    int unsigned k;
    forever begin
      k = calm ? 0 : $urandom_range(0, 19);
      if (k > 0) begin
        out_bus.ready <= 1'b0;
        repeat (k) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.token_kind, out_bus.token_value, out_bus.item_count,
              out_bus.nest_level, out_bus.error_code, out_bus.doc_done};
      if (token_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          n_errors++;
          $display("%0t: mismatch, expected kind %0d val %h cnt %0d lvl %0d err %0d done %0d",
                   $time, want.kind, want.value, want.count, want.level, want.err,
                   want.done);
          $display("%0t:          actual kind %0d val %h cnt %0d lvl %0d err %0d done %0d",
                   $time, got.kind, got.value, got.count, got.level, got.err, got.done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    n_errors   = 0;
    bytes_sent = 0;
    cycles     = 0;
    calm       = 1'b0;
    doc_clear();
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= '0;
    in_bus.doc_length <= '0;
    in_bus.last_byte  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_scalars();
    test_nesting();
    test_errors();
    test_random();

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && token_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/msd_pkg.sv
hdl/msd_if.sv
hdl/msd_ram.sv
hdl/msd_ctrl.sv
hdl/msd_dp.sv
hdl/msgpack_stream_decoder_top.sv
sim/tb_top.sv
